// File: rtl/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

   // Fixed field widths of the request, response and control register
   localparam int KIND_W       = 2;
   localparam int HASH_W       = 64;
   localparam int LEN_PORT_W   = 32;
   localparam int NUM_PORT_W   = 32;
   localparam int STATUS_W     = 2;
   localparam int SLOT_PORT_W  = 16;
   localparam int TB_W         = 5;

   // table_bits after reset
   localparam logic [TB_W-1:0] TB_RESET = 5'd16;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_FIRST = 2'd1,
      KIND_NEXT  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT  = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_DONE = 2'd2,
      STATUS_FULL = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: rtl/lpht_if.sv
`default_nettype none

// Request channel: operation plus key
interface lpht_req_if;
   logic                            valid;
   logic                            ready;
   logic [lpht_pkg::KIND_W-1:0]     kind;
   logic [lpht_pkg::HASH_W-1:0]     key_hash;
   logic [lpht_pkg::LEN_PORT_W-1:0] key_length;
   logic [lpht_pkg::NUM_PORT_W-1:0] seq_number;

   modport source (output valid, kind, key_hash, key_length, seq_number, input ready);
   modport sink   (input valid, kind, key_hash, key_length, seq_number, output ready);
endinterface

// Response channel: one per request
interface lpht_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lpht_pkg::STATUS_W-1:0]    status;
   logic [lpht_pkg::NUM_PORT_W-1:0]  found_number;
   logic [lpht_pkg::SLOT_PORT_W-1:0] slot_index;

   modport source (output valid, status, found_number, slot_index, input ready);
   modport sink   (input valid, status, found_number, slot_index, output ready);
endinterface

`default_nettype wire

// File: rtl/lpht_slot_mem.sv
`default_nettype none

// Slot store: one write port, one read port, registered read data
module lpht_slot_mem #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 129
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] slot_mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/linear_probe_hash_table.sv
`default_nettype none

// Linear-probing hash table of 2^ADDR_BITS slots, of which 2^table_bits (capped at
// ADDR_BITS) are in use. Each request returns exactly one response. An add or a
// search is accepted in idle, then probes n slots (one slot read per cycle from the
// slot memory, n up to 2^table_bits) and then hands the result to the rsp register.
// That hand-off waits while an earlier response still sits unaccepted on rsp, and req
// ready stays low meanwhile. A clear sweeps the whole slot memory, one slot per cycle.
// After reset the same sweep runs with req ready low; csr writes are taken at any time
// but must only be issued while the table is idle. A new request can be accepted while
// the previous response still waits on rsp.
module linear_probe_hash_table #(
   parameter int ADDR_BITS   = 16,
   parameter int LEN_BITS    = 32,
   parameter int NUMBER_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   lpht_req_if.sink                  req_chan,
   lpht_rsp_if.source                rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [lpht_pkg::TB_W-1:0] csr_wr_data
);

   localparam int HASH_W  = lpht_pkg::HASH_W;
   localparam int LEN_PW  = lpht_pkg::LEN_PORT_W;
   localparam int NUM_PW  = lpht_pkg::NUM_PORT_W;
   localparam int SLOT_OW = lpht_pkg::SLOT_PORT_W;
   localparam int TB_W    = lpht_pkg::TB_W;
   localparam int LEN_W   = (LEN_BITS < LEN_PW) ? LEN_BITS : LEN_PW;
   localparam int NUM_W   = (NUMBER_BITS < NUM_PW) ? NUMBER_BITS : NUM_PW;
   localparam int SLOT_XW = (ADDR_BITS > SLOT_OW) ? ADDR_BITS : SLOT_OW;
   localparam int ENTRY_W = 1 + HASH_W + LEN_W + NUM_W;
   localparam int LEN_LSB   = NUM_W;
   localparam int HASH_LSB  = NUM_W + LEN_W;
   localparam int VALID_BIT = ENTRY_W - 1;
   localparam logic [TB_W-1:0] ADDR_BITS_TB = TB_W'(ADDR_BITS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_DELIVER
   } state_type;

   state_type                   state_ff, state_in;
   logic [TB_W-1:0]             table_bits_ff, table_bits_in;
   logic                        clr_reply_ff, clr_reply_in;
   lpht_pkg::kind_type          kind_ff, kind_in;
   logic [HASH_W-1:0]           key_hash_ff, key_hash_in;
   logic [LEN_W-1:0]            key_len_ff, key_len_in;
   logic [NUM_W-1:0]            num_ff, num_in;
   logic [ADDR_BITS-1:0]        start_ff, start_in;
   logic [ADDR_BITS-1:0]        idx_ff, idx_in;
   logic [ADDR_BITS-1:0]        count_ff, count_in;
   logic [HASH_W-1:0]           ctx_hash_ff, ctx_hash_in;
   logic [LEN_W-1:0]            ctx_len_ff, ctx_len_in;
   logic [ADDR_BITS-1:0]        ctx_slot_ff, ctx_slot_in;
   lpht_pkg::status_type        res_status_ff, res_status_in;
   logic [NUM_W-1:0]            res_found_ff, res_found_in;
   logic [ADDR_BITS-1:0]        res_slot_ff, res_slot_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lpht_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [NUM_PW-1:0]           rsp_found_ff, rsp_found_in;
   logic [SLOT_OW-1:0]          rsp_slot_ff, rsp_slot_in;

   logic [TB_W-1:0]             tb_eff;
   logic [ADDR_BITS-1:0]        mask;
   logic [ADDR_BITS-1:0]        ctx_next;
   logic                        mem_wr_en;
   logic [ADDR_BITS-1:0]        mem_wr_addr;
   logic [ENTRY_W-1:0]          mem_wr_data;
   logic [ADDR_BITS-1:0]        mem_rd_addr;
   logic [ENTRY_W-1:0]          mem_rd_data;
   logic                        e_valid;
   logic [HASH_W-1:0]           e_hash;
   logic [LEN_W-1:0]            e_len;
   logic [NUM_W-1:0]            e_num;
   logic                        e_hit;
   logic                        run_done;
   lpht_pkg::kind_type          req_kind;

   // Index mask from the saturated table size
   assign tb_eff   = (table_bits_ff > ADDR_BITS_TB) ? ADDR_BITS_TB : table_bits_ff;
   assign mask     = ~({ADDR_BITS{1'b1}} << tb_eff);
   assign ctx_next = ((ctx_slot_ff & mask) + 1'b1) & mask;
   assign req_kind = lpht_pkg::kind_type'(req_chan.kind);

   // Slot entry fields
   assign e_valid  = mem_rd_data[VALID_BIT];
   assign e_hash   = mem_rd_data[HASH_LSB +: HASH_W];
   assign e_len    = mem_rd_data[LEN_LSB +: LEN_W];
   assign e_num    = mem_rd_data[0 +: NUM_W];
   assign e_hit    = (kind_ff != lpht_pkg::KIND_ADD) && (e_hash == key_hash_ff) &&
                     (e_len == key_len_ff);
   assign run_done = !e_valid || e_hit || (count_ff == mask);

   lpht_slot_mem #(
      .ADDR_W (ADDR_BITS),
      .DATA_W (ENTRY_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      table_bits_in = table_bits_ff;
      clr_reply_in  = clr_reply_ff;
      kind_in       = kind_ff;
      key_hash_in   = key_hash_ff;
      key_len_in    = key_len_ff;
      num_in        = num_ff;
      start_in      = start_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      ctx_hash_in   = ctx_hash_ff;
      ctx_len_in    = ctx_len_ff;
      ctx_slot_in   = ctx_slot_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = '0;
      // speculative read of the next slot in the run
      mem_rd_addr   = (idx_ff + 1'b1) & mask;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         table_bits_in = csr_wr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            // sweep every slot, invalidating it
            mem_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == {ADDR_BITS{1'b1}}) begin
               clr_reply_in = 1'b0;
               if (clr_reply_ff) begin
                  res_status_in = lpht_pkg::STATUS_DONE;
                  res_found_in  = '0;
                  res_slot_in   = '0;
                  state_in      = ST_DELIVER;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_kind == lpht_pkg::KIND_CLEAR) begin
                  idx_in       = '0;
                  clr_reply_in = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  kind_in  = req_kind;
                  num_in   = NUM_W'(req_chan.seq_number);
                  count_in = '0;
                  if (req_kind == lpht_pkg::KIND_NEXT) begin
                     key_hash_in = ctx_hash_ff;
                     key_len_in  = ctx_len_ff;
                     start_in    = ctx_next;
                  end else begin
                     key_hash_in = req_chan.key_hash;
                     key_len_in  = LEN_W'(req_chan.key_length);
                     start_in    = req_chan.key_hash[ADDR_BITS-1:0] & mask;
                  end
                  idx_in      = start_in;
                  mem_rd_addr = start_in;
                  state_in    = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (run_done) begin
               res_found_in = '0;
               res_slot_in  = idx_ff;
               if (!e_valid) begin
                  if (kind_ff == lpht_pkg::KIND_ADD) begin
                     // fill the first empty slot
                     mem_wr_en     = 1'b1;
                     mem_wr_data   = {1'b1, key_hash_ff, key_len_ff, num_ff};
                     res_status_in = lpht_pkg::STATUS_DONE;
                  end else begin
                     res_status_in = lpht_pkg::STATUS_MISS;
                  end
               end else if (e_hit) begin
                  res_status_in = lpht_pkg::STATUS_HIT;
                  res_found_in  = e_num;
               end else begin
                  // whole table probed
                  res_status_in = lpht_pkg::STATUS_FULL;
                  res_slot_in   = start_ff;
               end
               // searches save their context
               if (kind_ff != lpht_pkg::KIND_ADD) begin
                  ctx_hash_in = key_hash_ff;
                  ctx_len_in  = key_len_ff;
                  ctx_slot_in = res_slot_in;
               end
               state_in = ST_DELIVER;
            end else begin
               idx_in   = (idx_ff + 1'b1) & mask;
               count_in = count_ff + 1'b1;
            end
         end
         ST_DELIVER: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = NUM_PW'(res_found_ff);
               rsp_slot_in   = SLOT_OW'(SLOT_XW'(res_slot_ff));
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         table_bits_ff <= lpht_pkg::TB_RESET;
         clr_reply_ff  <= 1'b0;
         idx_ff        <= '0;
         count_ff      <= '0;
         ctx_hash_ff   <= '0;
         ctx_len_ff    <= '0;
         ctx_slot_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_bits_ff <= table_bits_in;
         clr_reply_ff  <= clr_reply_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         ctx_hash_ff   <= ctx_hash_in;
         ctx_len_ff    <= ctx_len_in;
         ctx_slot_ff   <= ctx_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      key_hash_ff   <= key_hash_in;
      key_len_ff    <= key_len_in;
      num_ff        <= num_in;
      start_ff      <= start_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_number = rsp_found_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;

   // an add only ever overwrites an empty slot
   a_add_fills_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && mem_wr_en) |-> !e_valid)
      else $error("add wrote over an occupied slot");

   // probe count never runs past the table size
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (count_ff <= mask))
      else $error("probe run longer than the table");

   // probe index stays inside the slots in use
   a_idx_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> ((idx_ff & ~mask) == '0))
      else $error("probe index outside the table");

   // a response is only raised from the delivery step
   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("response raised outside delivery");

   // reset always starts the clearing sweep
   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (state_ff == ST_CLEAR && idx_ff == '0))
      else $error("clearing sweep did not start after reset");

endmodule

`default_nettype wire
